// ----- rtl/core/linked_list_manager_top_defines.svh -----
// Assertion macros shared by the checker.
`ifndef LINKED_LIST_MANAGER_TOP_DEFINES_SVH
`define LINKED_LIST_MANAGER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/llm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package llm_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int ELEM_W   = 32;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 40;

  typedef logic [2:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_APPEND = 3'd0;
  localparam cmd_t CMD_FRONT  = 3'd1;
  localparam cmd_t CMD_AT_POS = 3'd2;
  localparam cmd_t CMD_DELETE = 3'd3;
  localparam cmd_t CMD_READ   = 3'd4;

  localparam status_t ST_DONE  = 3'd0;
  localparam status_t ST_NOEFF = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_ELEM  = 3'd3;
  localparam status_t ST_EMPTY = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_ALLOC,
    S_LINK2,
    S_DEL,
    S_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    start_walk;
    logic    fs_read;
    logic    step;
    logic    alloc;
    logic    link2;
    logic    unlink;
    logic    emit_code;
    logic    emit_elem;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic pos_one;
    logic pos_bad;
    logic at_target;
    logic at_last;
    logic match;
    logic out_free;
    logic need_link2;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/llm_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module llm_dpath
  import llm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              in_tuser,
  input  wire logic [DATA_W-1:0] in_tdata,
  input  wire dp_cmd_t           ctl,
  output dp_sts_t                sts,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,
  output status_t                out_tuser,
  output logic                   out_tlast
);

  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [IDX_W-1:0]   lnk_mem [CAPACITY];
  logic [IDX_W-1:0]   fs_mem_r [CAPACITY];
  logic [CAPACITY-1:0] fs_vld_r;

  cmd_t               cmd_r;
  logic [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]   pos_r;
  logic [IDX_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt, free_top_r, free_top_nxt;
  logic [IDX_W-1:0]   cur_r, prev_r, lk_r, fs_rd_r;
  logic [CNT_W-1:0]   i_r;
  logic [VALUE_W-1:0] vl_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ELEM_W-1:0]  out_elem_r;
  logic               out_last_r;
  logic [CNT_W-1:0]   out_len_r;

  logic [POS_W-1:0]   steps;
  logic [IDX_W-1:0]   rd_addr, fs_ra, fs_wa, lw_addr, lw_data;
  logic               lw_en, is_front;

  always_comb begin
    steps          = (pos_r == '0) ? '0 : pos_r - POS_W'(2);
    is_front       = (cmd_r == CMD_FRONT) || (cmd_r == CMD_AT_POS && pos_r == POS_W'(1));
    sts.cmd        = cmd_r;
    sts.full       = (count_r == CNT_W'(CAPACITY));
    sts.empty      = (count_r == '0);
    sts.pos_one    = (pos_r == POS_W'(1));
    sts.pos_bad    = (CNT_W'(steps) >= count_r) || (steps >= POS_W'(CAPACITY));
    sts.at_target  = (i_r == CNT_W'(steps));
    sts.at_last    = (CNT_W'(i_r + 1'b1) == count_r);
    sts.match      = (vl_r == val_r);
    sts.out_free   = !out_valid_r || out_tready;
    sts.need_link2 = (cmd_r == CMD_APPEND && count_r != '0) ||
                     (cmd_r == CMD_AT_POS && pos_r != POS_W'(1));
    rd_addr        = ctl.start_walk ? head_r : lk_r;
    fs_ra          = IDX_W'(free_top_r - 1'b1);
    fs_wa          = free_top_r[IDX_W-1:0];
  end

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = fs_rd_r;
    lw_data = '0;
    if (ctl.alloc) begin
      lw_en = 1'b1;
      if (is_front) begin
        lw_data = head_r;
      end else if (cmd_r == CMD_AT_POS) begin
        lw_data = lk_r;
      end
    end else if (ctl.link2) begin
      lw_en   = 1'b1;
      lw_addr = cur_r;
      lw_data = fs_rd_r;
    end else if (ctl.unlink && i_r != '0) begin
      lw_en   = 1'b1;
      lw_addr = prev_r;
      lw_data = lk_r;
    end
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    free_top_nxt = free_top_r;
    if (ctl.alloc) begin
      count_nxt    = count_r + 1'b1;
      free_top_nxt = free_top_r - 1'b1;
      if (cmd_r == CMD_APPEND) begin
        if (count_r == '0) begin
          head_nxt = fs_rd_r;
        end
        tail_nxt = fs_rd_r;
      end else if (is_front) begin
        if (count_r == '0) begin
          tail_nxt = fs_rd_r;
        end
        head_nxt = fs_rd_r;
      end else if (cur_r == tail_r) begin
        tail_nxt = fs_rd_r;
      end
    end else if (ctl.unlink) begin
      count_nxt    = count_r - 1'b1;
      free_top_nxt = free_top_r + 1'b1;
      if (i_r == '0) begin
        head_nxt = lk_r;
      end
      if (sts.at_last) begin
        tail_nxt = prev_r;
      end
      if (count_r == CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      free_top_r  <= CNT_W'(CAPACITY);
      fs_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      free_top_r <= free_top_nxt;
      if (ctl.unlink) begin
        fs_vld_r[fs_wa] <= 1'b1;
      end
      if (ctl.emit_code || ctl.emit_elem) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r <= in_tuser;
      val_r <= in_tdata[VALUE_W-1:0];
      pos_r <= in_tdata[ELEM_W +: POS_W];
    end
    if (ctl.start_walk) begin
      cur_r  <= head_r;
      prev_r <= head_r;
      i_r    <= '0;
    end else if (ctl.step) begin
      prev_r <= cur_r;
      cur_r  <= lk_r;
      i_r    <= i_r + 1'b1;
    end else if (ctl.alloc && cmd_r == CMD_APPEND) begin
      cur_r <= tail_r;
    end
    if (ctl.start_walk || ctl.step) begin
      vl_r <= val_mem[rd_addr];
      lk_r <= lnk_mem[rd_addr];
    end
    if (ctl.fs_read) begin
      fs_rd_r <= fs_vld_r[fs_ra] ? fs_mem_r[fs_ra] : fs_ra;
    end
    if (ctl.unlink) begin
      fs_mem_r[fs_wa] <= cur_r;
    end
    if (ctl.alloc) begin
      val_mem[fs_rd_r] <= val_r;
    end
    if (lw_en) begin
      lnk_mem[lw_addr] <= lw_data;
    end
    if (ctl.emit_code) begin
      out_status_r <= ctl.code;
      out_elem_r   <= '0;
      out_last_r   <= 1'b1;
      out_len_r    <= count_r;
    end else if (ctl.emit_elem) begin
      out_status_r <= ST_ELEM;
      out_elem_r   <= ELEM_W'(signed'(vl_r));
      out_last_r   <= sts.at_last;
      out_len_r    <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(DATA_W - ELEM_W - CNT_W)'(0), out_len_r, out_elem_r};

endmodule
`default_nettype wire

// ----- rtl/core/llm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module llm_ctrl
  import llm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      ctl
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    ctl       = '0;
    ctl.code  = code_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMIT;
        code_nxt  = ST_NOEFF;
        priority if (sts.cmd == CMD_APPEND || sts.cmd == CMD_FRONT ||
                     sts.cmd == CMD_AT_POS) begin
          if (sts.full) begin
            code_nxt = ST_FULL;
          end else if (sts.cmd == CMD_AT_POS && !sts.pos_one) begin
            if (!sts.empty && !sts.pos_bad) begin
              ctl.start_walk = 1'b1;
              ctl.fs_read    = 1'b1;
              state_nxt      = S_WALK;
            end
          end else begin
            ctl.fs_read = 1'b1;
            state_nxt   = S_ALLOC;
          end
        end else if (sts.cmd == CMD_DELETE) begin
          if (!sts.empty) begin
            ctl.start_walk = 1'b1;
            state_nxt      = S_DEL;
          end
        end else if (sts.cmd == CMD_READ) begin
          if (sts.empty) begin
            code_nxt = ST_EMPTY;
          end else begin
            ctl.start_walk = 1'b1;
            state_nxt      = S_RD;
          end
        end else begin
          code_nxt = ST_NOEFF;
        end
      end
      S_WALK: begin
        if (sts.at_target) begin
          state_nxt = S_ALLOC;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_ALLOC: begin
        ctl.alloc = 1'b1;
        code_nxt  = ST_DONE;
        state_nxt = sts.need_link2 ? S_LINK2 : S_EMIT;
      end
      S_LINK2: begin
        ctl.link2 = 1'b1;
        state_nxt = S_EMIT;
      end
      S_DEL: begin
        if (sts.match) begin
          ctl.unlink = 1'b1;
          code_nxt   = ST_DONE;
          state_nxt  = S_EMIT;
        end else if (sts.at_last) begin
          code_nxt  = ST_NOEFF;
          state_nxt = S_EMIT;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_RD: begin
        if (sts.out_free) begin
          ctl.emit_elem = 1'b1;
          if (sts.at_last) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.step = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_code = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/linked_list_manager_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Ordered singly linked list of up to 64 signed values with a free-slot stack. One command
// is taken at a time. A front insert, an insert at position one and an append to an empty
// list pass through decode, alloc and emit. An append to a non-empty list adds a link2 step
// before emit. Any other positional insert walks the list node by node before alloc, link2
// and emit. A delete compares the nodes in turn until a match or the tail, then emits, and a
// refused or ignored command goes from decode straight to emit. A read-out streams the
// elements from head to tail and waits under output back-pressure. The walk is bound by the
// single registered read port of the node memories, one node per cycle.
module linked_list_manager_top
  import llm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // item_value[31:0], position[38:32]
  input  wire cmd_t              in_tuser,   // cmd
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // element_value[31:0], length[38:32]
  output status_t                out_tuser,  // status
  output logic                   out_tlast
);

  dp_cmd_t ctl;
  dp_sts_t sts;

  llm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  llm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/core/llm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_manager_top_defines.svh"
module llm_checker
  import llm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [DATA_W-1:0] in_tdata,
  input wire cmd_t              in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [DATA_W-1:0] out_tdata,
  input wire status_t           out_tuser,
  input wire logic              out_tlast
);

  `LLM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata) && $stable(in_tuser), "Waiting input beat changed.")
  `LLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "Stalled result beat changed.")
  `LLM_ASSERT_NOW(a_elem_len, clk, rst_n, out_tvalid && out_tuser == ST_ELEM, out_tdata[38:32] != '0, "Listed element with zero length.")
  `LLM_ASSERT_NOW(a_code_last, clk, rst_n, out_tvalid && out_tuser != ST_ELEM, out_tlast && out_tdata[31:0] == '0, "Status beat not single or carries a value.")
  `LLM_ASSERT_NOW(a_len_max, clk, rst_n, out_tvalid, out_tdata[38:32] <= 7'(CAPACITY), "Length beyond capacity.")

endmodule

bind linked_list_manager_top llm_checker u_chk (.*);
`default_nettype wire

// ----- tb/tb_linked_list_manager_top.sv -----
`timescale 1ns / 1ps
module tb_linked_list_manager_top;
  import llm_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
    logic [6:0]  position;
  } list_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] element;
    logic        last;
    logic [6:0]  length;
  } list_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  cmd_t              in_tuser = CMD_APPEND;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  status_t           out_tuser;
  logic              out_tlast;

  linked_list_manager_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Shadow of the list kept in order, head first.
  logic [31:0] shadow_list[$];
  list_cmd_t   pending_cmds[$];
  list_resp_t  expected_resps[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          stim_done = 1'b0;

  task automatic push_resp(status_t st, logic [31:0] el, logic lst);
    list_resp_t r;
    r.status = st;
    r.element = el;
    r.last = lst;
    r.length = 7'(shadow_list.size());
    expected_resps.push_back(r);
  endtask

  task automatic apply_list_cmd(list_cmd_t c);
    int n;
    int idx;
    n = shadow_list.size();
    if (c.cmd inside {CMD_APPEND, CMD_FRONT, CMD_AT_POS} && n == CAPACITY) begin
      push_resp(ST_FULL, '0, 1'b1);
    end else if (c.cmd == CMD_AT_POS && c.position != 7'd1) begin
      idx = (c.position == 0) ? 1 : int'(c.position) - 1;
      if (n == 0 || idx > n) begin
        push_resp(ST_NOEFF, '0, 1'b1);
      end else begin
        shadow_list.insert(idx, c.value);
        push_resp(ST_DONE, '0, 1'b1);
      end
    end else if (c.cmd == CMD_APPEND) begin
      shadow_list.push_back(c.value);
      push_resp(ST_DONE, '0, 1'b1);
    end else if (c.cmd == CMD_FRONT || c.cmd == CMD_AT_POS) begin
      shadow_list.push_front(c.value);
      push_resp(ST_DONE, '0, 1'b1);
    end else if (c.cmd == CMD_DELETE) begin
      idx = -1;
      for (int i = 0; i < n; i++) begin
        if (idx < 0 && shadow_list[i] == c.value) idx = i;
      end
      if (idx >= 0) begin
        shadow_list.delete(idx);
        push_resp(ST_DONE, '0, 1'b1);
      end else begin
        push_resp(ST_NOEFF, '0, 1'b1);
      end
    end else if (c.cmd == CMD_READ) begin
      if (n == 0) push_resp(ST_EMPTY, '0, 1'b1);
      for (int i = 0; i < n; i++) push_resp(ST_ELEM, shadow_list[i], i == n - 1);
    end else begin
      push_resp(ST_NOEFF, '0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    list_cmd_t c;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_list_cmd({in_tuser, in_tdata[31:0], in_tdata[38:32]});
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_cmds.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.cmd;
          in_tdata <= {1'b0, c.position, c.value};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_resp_t got;
    list_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tlast, out_tdata[38:32]};
      if (expected_resps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = expected_resps.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic list_cmd_t make_cmd(cmd_t cmd, logic [31:0] v, logic [6:0] p);
    list_cmd_t c;
    c.cmd = cmd;
    c.value = v;
    c.position = p;
    return c;
  endfunction

  // Most values come from a small set so that deletes often hit.
  function automatic list_cmd_t rand_cmd();
    logic [31:0] v;
    int          k;
    v = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(15)) - 32'd8;
    k = $urandom_range(99);
    if (k < 30) return make_cmd(CMD_APPEND, v, 7'($urandom()));
    if (k < 45) return make_cmd(CMD_FRONT, v, 7'($urandom()));
    if (k < 65) return make_cmd(CMD_AT_POS, v,
                                ($urandom_range(5) == 0) ? 7'($urandom()) :
                                                           7'($urandom_range(20)));
    if (k < 85) return make_cmd(CMD_DELETE, v, 7'($urandom()));
    if (k < 97) return make_cmd(CMD_READ, v, 7'($urandom()));
    return make_cmd(cmd_t'($urandom_range(7, 5)), v, 7'($urandom()));
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_resps.size() > 0) @(posedge clk);
  endtask

  initial begin
    int fill_cnt;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    pending_cmds.push_back(make_cmd(CMD_READ, 32'd0, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'd5, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd1, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd1, 7'd2));
    pending_cmds.push_back(make_cmd(CMD_APPEND, 32'h7fffffff, 7'h7f));
    pending_cmds.push_back(make_cmd(CMD_FRONT, 32'h80000000, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'hffffffff, 7'd1));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd0, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'h55555555, 7'd5));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'haaaaaaaa, 7'd3));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd9, 7'd9));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd9, 7'h7f));
    pending_cmds.push_back(make_cmd(CMD_READ, 32'd0, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'h80000000, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'h55555555, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'h7fffffff, 7'd0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'd1234, 7'd0));
    pending_cmds.push_back(make_cmd(cmd_t'(5), 32'd0, 7'd0));
    pending_cmds.push_back(make_cmd(cmd_t'(7), 32'hffffffff, 7'h7f));
    pending_cmds.push_back(make_cmd(CMD_READ, 32'd0, 7'd0));
    wait_drained();
    // Fill the pool past capacity to see the inserts beyond it refused.
    fill_cnt = CAPACITY - shadow_list.size() + 2;
    for (int i = 0; i < fill_cnt; i++)
      pending_cmds.push_back(make_cmd(CMD_APPEND, $urandom(), 7'd0));
    pending_cmds.push_back(make_cmd(CMD_FRONT, 32'd1, 7'd1));
    pending_cmds.push_back(make_cmd(CMD_AT_POS, 32'd1, 7'd3));
    pending_cmds.push_back(make_cmd(CMD_READ, 32'd0, 7'd0));
    wait_drained();
    for (int i = 0; i < CAPACITY / 4; i++)
      pending_cmds.push_back(make_cmd(CMD_DELETE, shadow_list[i], 7'd0));
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 35) : 0;
      recv_stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 35 : 0);
      for (int i = 0; i < 8; i++) pending_cmds.push_back(rand_cmd());
      wait_drained();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_resps.size() == 0) begin
      $display("tb_linked_list_manager_top passed");
    end else begin
      $display("tb_linked_list_manager_top failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= 400000);
    $display("tb_linked_list_manager_top failed");
    $finish;
  end
endmodule
